### rtl/signed_int_to_radix_digits_unit_defines.svh
// Assertion macros for the radix digits unit checker.
// No dependencies; include by bare file name.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SIRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SIRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sird_pkg.sv
// Shared types, constants and helpers for the radix digits unit.
// No dependencies.
package sird_pkg;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned NUM_CFG_REGS = 8;
  localparam int unsigned CFG_IDX_W    = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DIVW,
    ST_SIGN,
    ST_POP,
    ST_LOAD,
    ST_OUT
  } sird_state_e;

  typedef struct packed {
    logic done;
    logic ok;
  } sird_scan_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ||
           ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z)) ||
           ((c >= CHAR_D0) && (c <= CHAR_D9));
  endfunction

endpackage

### rtl/sird_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sird_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sird_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module sird_div #(
  parameter int unsigned NUMBER_WIDTH = 32,
  parameter int unsigned RADIX_W      = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NUMBER_WIDTH-1:0] dividend_i,
  input  logic [RADIX_W-1:0]      divisor_i,
  output logic                    done_o,
  output logic [NUMBER_WIDTH-1:0] quo_o,
  output logic [RADIX_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(NUMBER_WIDTH);

  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [NUMBER_WIDTH-1:0] quo_q, quo_d;
  logic [RADIX_W-1:0]      rem_q, rem_d;
  logic [RADIX_W:0]        trial;
  logic [RADIX_W:0]        diff;
  logic                    geq;

  assign trial = {rem_q, quo_q[NUMBER_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign geq   = trial >= {1'b0, divisor_i};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(NUMBER_WIDTH - 1);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      quo_d = {quo_q[NUMBER_WIDTH-2:0], geq};
      rem_d = geq ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### rtl/sird_scan.sv
// Alphabet scanner: finds the length and checks characters, one per cycle.
// Depends on sird_pkg.
module sird_scan #(
  parameter int unsigned MAX_ALPHABET = 64
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  start_i,
  input  logic [MAX_ALPHABET-1:0][sird_pkg::CHAR_W-1:0]         alpha_i,
  output sird_pkg::sird_scan_t                                  status_o,
  output logic [$clog2(MAX_ALPHABET+1)-1:0]                     radix_o
);
  import sird_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ALPHABET + 1);
  localparam int unsigned AW    = (MAX_ALPHABET > 1) ? $clog2(MAX_ALPHABET) : 1;

  logic              run_q, run_d;
  logic              ok_q, ok_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CHAR_W-1:0] cur;
  logic              at_end;
  logic              dup;

  assign cur    = alpha_i[idx_q[AW-1:0]];
  assign at_end = (idx_q == IDX_W'(MAX_ALPHABET)) || (cur == '0);

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_ALPHABET; j++) begin
      dup = dup | ((IDX_W'(j) < idx_q) && (alpha_i[j] == cur));
    end
  end

  always_comb begin
    run_d    = run_q;
    ok_d     = ok_q;
    idx_d    = idx_q;
    status_o = '0;
    if (start_i) begin
      run_d = 1'b1;
      ok_d  = 1'b1;
      idx_d = '0;
    end else if (run_q) begin
      if (at_end) begin
        run_d       = 1'b0;
        status_o.done = 1'b1;
        status_o.ok   = ok_q && (idx_q >= IDX_W'(2));
      end else begin
        ok_d  = ok_q && is_alnum(cur) && !dup;
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q  <= ok_d;
    idx_q <= idx_d;
  end

  assign radix_o = idx_q;

endmodule

### rtl/signed_int_to_radix_digits_unit.sv
// Flow: an alphabet scan of up to MAX_ALPHABET characters, then one bit-serial
// division per digit, then a minus sign for a negative number and the digits,
// most significant first, each held until out_ready_i. One number at a time:
// in_ready_o is high only when idle. Reset clears control state and the
// alphabet registers.
module signed_int_to_radix_digits_unit #(
  parameter int unsigned NUMBER_WIDTH = 32,
  parameter int unsigned MAX_ALPHABET = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sird_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sird_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [NUMBER_WIDTH-1:0]   number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sird_pkg::CHAR_W-1:0]      out_char_o,
  output logic                             last_char_o
);
  import sird_pkg::*;

  localparam int unsigned RADIX_W = $clog2(MAX_ALPHABET + 1);
  localparam int unsigned DIGIT_W = (MAX_ALPHABET > 1) ? $clog2(MAX_ALPHABET) : 1;
  localparam int unsigned CNT_W   = $clog2(NUMBER_WIDTH + 1);
  localparam int unsigned SW      = $clog2(NUMBER_WIDTH);

  logic [NUM_CFG_REGS-1:0][CFG_DATA_W-1:0]       cfg_q;
  logic [NUM_CFG_REGS*8-1:0][CHAR_W-1:0]         alpha_all;
  logic [MAX_ALPHABET-1:0][CHAR_W-1:0]           alpha;

  sird_state_e             state_q, state_d;
  logic                    neg_q, neg_d;
  logic [NUMBER_WIDTH-1:0] mag_q, mag_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CHAR_W-1:0]       char_q, char_d;
  logic                    last_q, last_d;

  sird_scan_t              scan_st;
  logic [RADIX_W-1:0]      radix;
  logic                    div_start;
  logic                    div_done;
  logic [NUMBER_WIDTH-1:0] div_quo;
  logic [RADIX_W-1:0]      div_rem;
  logic                    stk_we;
  logic [SW-1:0]           stk_raddr;
  logic [DIGIT_W-1:0]      stk_rdata;
  logic                    in_acc;

  assign alpha_all = cfg_q;
  assign alpha     = alpha_all[MAX_ALPHABET-1:0];

  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(NUM_CFG_REGS))) begin
      cfg_q[cfg_index_i[$clog2(NUM_CFG_REGS)-1:0]] <= cfg_data_i;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  sird_scan #(
    .MAX_ALPHABET(MAX_ALPHABET)
  ) u_scan (
    .clk_i,
    .rst_ni,
    .start_i (in_acc),
    .alpha_i (alpha),
    .status_o(scan_st),
    .radix_o (radix)
  );

  sird_div #(
    .NUMBER_WIDTH(NUMBER_WIDTH),
    .RADIX_W     (RADIX_W)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(mag_q),
    .divisor_i (radix),
    .done_o    (div_done),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  sird_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(NUMBER_WIDTH)
  ) u_stack (
    .clk_i,
    .we_i   (stk_we),
    .waddr_i(cnt_q[SW-1:0]),
    .wdata_i(div_rem[DIGIT_W-1:0]),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  assign stk_raddr = SW'(cnt_q - 1'b1);

  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    cnt_d     = cnt_q;
    char_d    = char_q;
    last_d    = last_q;
    div_start = 1'b0;
    stk_we    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_d   = number_i[NUMBER_WIDTH-1];
          mag_d   = number_i[NUMBER_WIDTH-1] ? NUMBER_WIDTH'(-number_i) : number_i;
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_st.done) begin
          state_d = scan_st.ok ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          stk_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          mag_d  = div_quo;
          if (div_quo != '0) begin
            state_d = ST_DIV;
          end else if (neg_q) begin
            char_d  = CHAR_MINUS;
            last_d  = 1'b0;
            state_d = ST_SIGN;
          end else begin
            state_d = ST_POP;
          end
        end
      end
      ST_SIGN: begin
        if (out_ready_i) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        cnt_d   = cnt_q - 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        char_d  = alpha[stk_rdata];
        last_d  = (cnt_q == '0);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = (cnt_q == '0) ? ST_IDLE : ST_POP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      mag_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mag_q   <= mag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = (state_q == ST_SIGN) || (state_q == ST_OUT);
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

endmodule

### rtl/sird_checker.sv
// Port-level checker for the radix digits unit, bound to the top level.
// Depends on sird_pkg and signed_int_to_radix_digits_unit_defines.svh.
`include "signed_int_to_radix_digits_unit_defines.svh"

module sird_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [sird_pkg::CHAR_W-1:0]      out_char_o,
  input logic                             last_char_o
);

  `SIRD_ASSERT_IMP(a_busy_while_out, out_valid_o, !in_ready_o, "request taken while output pending")
  `SIRD_ASSERT_NXT(a_no_out_after_req, in_valid_i && in_ready_o, !out_valid_o, "output right after request")
  `SIRD_ASSERT_NXT(a_more_after_mid, out_valid_o && out_ready_i && !last_char_o, !in_ready_o, "idle before last character")
  `SIRD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_char_o) && $stable(last_char_o), "stalled output changed")

endmodule

bind signed_int_to_radix_digits_unit sird_checker u_sird_checker (.*);
